// ----- hdl/bsu_pkg.sv -----
// Shared types, codes and command/status structs of the bytecode stack unit.
`default_nettype none
package bsu_pkg;

    localparam int STACK_DEPTH_DEF = 32;
    localparam int VALUE_W         = 32;
    localparam int OPCODE_W        = 3;
    localparam int STATUS_W        = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH = 3'd0,
        OP_DUMP = 3'd1,
        OP_PEEK = 3'd2,
        OP_POP  = 3'd3,
        OP_SWAP = 3'd4
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_SHORT    = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_INC  = 2'd1,
        CNT_DEC  = 2'd2
    } cnt_op_t;

    typedef enum logic [1:0] {
        RD_NONE     = 2'd0,
        RD_TOP      = 2'd1,
        RD_SECOND   = 2'd2,
        RD_IDX_NEXT = 2'd3
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE       = 2'd0,
        WR_PUSH       = 2'd1,
        WR_TOP_RDATA  = 2'd2,
        WR_SECOND_TMP = 2'd3
    } wr_sel_t;

    typedef enum logic [1:0] {
        IDX_HOLD     = 2'd0,
        IDX_LOAD_TOP = 2'd1,
        IDX_DEC      = 2'd2
    } idx_op_t;

    typedef struct packed {
        cnt_op_t cnt_op;
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
        idx_op_t idx_op;
        logic    tmp_load;
        logic    out_load;
        status_t out_status;
        logic    out_has;
        logic    out_last;
    } cmd_t;

    typedef struct packed {
        logic cnt_empty;
        logic cnt_few;
        logic cnt_full;
        logic idx_zero;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

// ----- hdl/bsu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bsu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- hdl/bsu_dpath.sv -----
// Datapath: entry count, dump index, swap holding register, stack RAM, result register.
`default_nettype none
module bsu_dpath #(
    parameter int STACK_DEPTH = bsu_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire bsu_pkg::cmd_t                cmd,
    output bsu_pkg::sts_t                     sts,
    input  wire logic [bsu_pkg::VALUE_W-1:0]  push_value,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [bsu_pkg::VALUE_W-1:0]  m_tdata,
    output logic      [2:0]                   m_tuser,
    output logic                              m_tlast
);

    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [AW-1:0]               idx_reg, idx_next;
    logic [bsu_pkg::VALUE_W-1:0] tmp_reg;
    logic                        vld_reg, vld_next;
    bsu_pkg::status_t            ost_reg;
    logic                        ohas_reg;
    logic                        olast_reg;
    logic [bsu_pkg::VALUE_W-1:0] odata_reg;

    logic [AW-1:0]               top_addr, second_addr;
    logic                        ram_we, ram_re;
    logic [AW-1:0]               ram_waddr, ram_raddr;
    logic [bsu_pkg::VALUE_W-1:0] ram_wdata, ram_rdata;

    assign top_addr    = cnt_reg[AW-1:0] - AW'(1);
    assign second_addr = cnt_reg[AW-1:0] - AW'(2);

    always_comb begin
        ram_re    = 1'b1;
        ram_raddr = top_addr;
        case (cmd.rd_sel)
            bsu_pkg::RD_NONE:     ram_re    = 1'b0;
            bsu_pkg::RD_TOP:      ram_raddr = top_addr;
            bsu_pkg::RD_SECOND:   ram_raddr = second_addr;
            bsu_pkg::RD_IDX_NEXT: ram_raddr = idx_reg - AW'(1);
            default:              ram_re    = 1'b0;
        endcase
    end

    always_comb begin
        ram_we    = 1'b1;
        ram_waddr = cnt_reg[AW-1:0];
        ram_wdata = push_value;
        case (cmd.wr_sel)
            bsu_pkg::WR_NONE: ram_we = 1'b0;
            bsu_pkg::WR_PUSH: begin
                ram_waddr = cnt_reg[AW-1:0];
                ram_wdata = push_value;
            end
            bsu_pkg::WR_TOP_RDATA: begin
                ram_waddr = top_addr;
                ram_wdata = ram_rdata;
            end
            bsu_pkg::WR_SECOND_TMP: begin
                ram_waddr = second_addr;
                ram_wdata = tmp_reg;
            end
            default: ram_we = 1'b0;
        endcase
    end

    bsu_ram #(
        .WIDTH (bsu_pkg::VALUE_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        case (cmd.cnt_op)
            bsu_pkg::CNT_INC: cnt_next = cnt_reg + CNT_W'(1);
            bsu_pkg::CNT_DEC: cnt_next = cnt_reg - CNT_W'(1);
            default:          cnt_next = cnt_reg;
        endcase
        case (cmd.idx_op)
            bsu_pkg::IDX_LOAD_TOP: idx_next = top_addr;
            bsu_pkg::IDX_DEC:      idx_next = idx_reg - AW'(1);
            default:               idx_next = idx_reg;
        endcase
    end

    // hold the result until taken; a new load may replace one being taken
    assign vld_next = cmd.out_load | (vld_reg & ~m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            vld_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (cmd.tmp_load) begin
            tmp_reg <= ram_rdata;
        end
        if (cmd.out_load) begin
            ost_reg   <= cmd.out_status;
            ohas_reg  <= cmd.out_has;
            olast_reg <= cmd.out_last;
            odata_reg <= cmd.out_has ? ram_rdata : '0;
        end
    end

    assign sts.cnt_empty = (cnt_reg == '0);
    assign sts.cnt_few   = (cnt_reg < CNT_W'(2));
    assign sts.cnt_full  = (cnt_reg == CNT_W'(STACK_DEPTH));
    assign sts.idx_zero  = (idx_reg == '0);
    assign sts.out_free  = ~vld_reg | m_tready;

    assign m_tvalid = vld_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = {ohas_reg, ost_reg};
    assign m_tlast  = olast_reg;

endmodule
`default_nettype wire

// ----- hdl/bsu_ctrl.sv -----
// Controller: decodes opcodes and sequences peek, dump and swap over the RAM.
`default_nettype none
module bsu_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [bsu_pkg::OPCODE_W-1:0]  opcode,
    input  wire bsu_pkg::sts_t                 sts,
    output bsu_pkg::cmd_t                      cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_EMIT   = 7'b0000010,
        S_PEEK   = 7'b0000100,
        S_DUMP   = 7'b0001000,
        S_SWAP_A = 7'b0010000,
        S_SWAP_B = 7'b0100000,
        S_SWAP_C = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    bsu_pkg::status_t pend_reg, pend_next;

    always_comb begin
        logic             emit_req;
        bsu_pkg::status_t emit_st;

        emit_req       = 1'b0;
        emit_st        = bsu_pkg::ST_OK;
        state_next     = state_reg;
        pend_next      = pend_reg;
        s_tready       = 1'b0;
        cmd.cnt_op     = bsu_pkg::CNT_HOLD;
        cmd.rd_sel     = bsu_pkg::RD_NONE;
        cmd.wr_sel     = bsu_pkg::WR_NONE;
        cmd.idx_op     = bsu_pkg::IDX_HOLD;
        cmd.tmp_load   = 1'b0;
        cmd.out_load   = 1'b0;
        cmd.out_status = bsu_pkg::ST_OK;
        cmd.out_has    = 1'b0;
        cmd.out_last   = 1'b1;

        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (bsu_pkg::opcode_t'(opcode))
                        bsu_pkg::OP_PUSH: begin
                            emit_req = 1'b1;
                            if (sts.cnt_full) begin
                                emit_st = bsu_pkg::ST_OVERFLOW;
                            end else begin
                                cmd.wr_sel = bsu_pkg::WR_PUSH;
                                cmd.cnt_op = bsu_pkg::CNT_INC;
                            end
                        end
                        bsu_pkg::OP_DUMP: begin
                            if (!sts.cnt_empty) begin
                                cmd.rd_sel = bsu_pkg::RD_TOP;
                                cmd.idx_op = bsu_pkg::IDX_LOAD_TOP;
                                state_next = S_DUMP;
                            end
                        end
                        bsu_pkg::OP_PEEK: begin
                            if (sts.cnt_empty) begin
                                emit_req = 1'b1;
                                emit_st  = bsu_pkg::ST_EMPTY;
                            end else begin
                                cmd.rd_sel = bsu_pkg::RD_TOP;
                                state_next = S_PEEK;
                            end
                        end
                        bsu_pkg::OP_POP: begin
                            emit_req = 1'b1;
                            if (sts.cnt_empty) begin
                                emit_st = bsu_pkg::ST_EMPTY;
                            end else begin
                                cmd.cnt_op = bsu_pkg::CNT_DEC;
                            end
                        end
                        bsu_pkg::OP_SWAP: begin
                            if (sts.cnt_few) begin
                                emit_req = 1'b1;
                                emit_st  = bsu_pkg::ST_SHORT;
                            end else begin
                                cmd.rd_sel = bsu_pkg::RD_TOP;
                                state_next = S_SWAP_A;
                            end
                        end
                        default: ; // drop unknown opcodes
                    endcase
                end
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = pend_reg;
                    state_next     = S_IDLE;
                end
            end
            S_PEEK: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_has  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_DUMP: begin
                // emit current entry and fetch the next one down in the same cycle
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_has  = 1'b1;
                    cmd.out_last = sts.idx_zero;
                    if (sts.idx_zero) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.rd_sel = bsu_pkg::RD_IDX_NEXT;
                        cmd.idx_op = bsu_pkg::IDX_DEC;
                    end
                end
            end
            S_SWAP_A: begin
                cmd.tmp_load = 1'b1;
                cmd.rd_sel   = bsu_pkg::RD_SECOND;
                state_next   = S_SWAP_B;
            end
            S_SWAP_B: begin
                cmd.wr_sel = bsu_pkg::WR_TOP_RDATA;
                state_next = S_SWAP_C;
            end
            S_SWAP_C: begin
                cmd.wr_sel = bsu_pkg::WR_SECOND_TMP;
                emit_req   = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase

        // single-result requests go straight to the result register when it is free
        if (emit_req) begin
            if (sts.out_free) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = emit_st;
                state_next     = S_IDLE;
            end else begin
                pend_next  = emit_st;
                state_next = S_EMIT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pend_reg  <= bsu_pkg::ST_OK;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/bytecode_stack_unit.sv -----
// Top level of the bytecode stack unit: controller plus datapath.
//
// Usage:
//   Each request on the s_ channel carries an opcode in s_tuser and a push
//   value in s_tdata. Push, pop, peek and swap each return one result with
//   m_tlast high; dump returns one result per stored entry, top first, with
//   m_tlast on the bottom entry, and nothing for an empty stack. Unknown
//   opcodes are taken and dropped. m_tuser carries the status code and the
//   has-value flag; m_tdata is zero when no entry is returned.
// Sequencing:
//   Push and pop: the result is loaded straight into the output register, so a
//   stream of them runs at one request per cycle while m_tready stays high.
//   Peek: one RAM read, then the result is loaded. Swap: two reads and two
//   writes through the one read port and the one write port of the stack RAM.
//   Dump: a RAM read to start, then one result per entry, one per cycle while m_tready is high.
//   Errors return their result straight from the idle state, like push and pop.
// Reset and stall:
//   aresetn clears the entry count and drops any pending result; the stack
//   RAM is not cleared. When m_tready is low the result holds in the output
//   register; one more request may be taken, then s_tready drops until the
//   held result is taken.
`default_nettype none
module bytecode_stack_unit #(
    parameter int STACK_DEPTH = bsu_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [bsu_pkg::VALUE_W-1:0]   s_tdata,  // [31:0] push_value
    input  wire logic [bsu_pkg::OPCODE_W-1:0]  s_tuser,  // [2:0] opcode
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [bsu_pkg::VALUE_W-1:0]   m_tdata,  // [31:0] data_value
    output logic      [2:0]                    m_tuser,  // [1:0] status, [2] has_value
    output logic                               m_tlast
);

    bsu_pkg::cmd_t cmd;
    bsu_pkg::sts_t sts;

    bsu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    bsu_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .push_value (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
`default_nettype wire

// ----- hdl/bsu_checker.sv -----
// Port-level checker for the bytecode stack unit, bound to the top level.
`default_nettype none
module bsu_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [bsu_pkg::VALUE_W-1:0]  m_tdata,
    input wire logic [2:0]                   m_tuser,
    input wire logic                         m_tlast
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
    else $error("result changed while stalled");

    // no pending result right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
    else $error("result valid after reset");

    // data is zero unless a stack entry is carried
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[2] |-> m_tdata == '0)
    else $error("data nonzero without value");

    // an entry is only returned with ok status
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tuser[1:0] == bsu_pkg::ST_OK)
    else $error("entry returned with error status");

    // errors always end the request
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] != bsu_pkg::ST_OK |-> m_tlast && !m_tuser[2])
    else $error("error result not final");

endmodule

bind bytecode_stack_unit bsu_checker u_bsu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
